>>> design/pfkd_pkg.sv
// Shared types, codes and keystream helper functions for the archive byte decryptor.
`timescale 1ns / 1ps
`default_nettype none
package pfkd_pkg;

	// Item action codes
	localparam logic [1:0] ACT_DECRYPT = 2'd0;
	localparam logic [1:0] ACT_SKIP    = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	// Register indexes (byte address is 8 * index)
	localparam logic [2:0] REG_ENCRYPT_ENABLE = 3'd0;
	localparam logic [2:0] REG_FILE_SIZE      = 3'd1;
	localparam logic [2:0] REG_KEY_A_LOW      = 3'd2;
	localparam logic [2:0] REG_KEY_A_HIGH     = 3'd3;
	localparam logic [2:0] REG_KEY_B_LOW      = 3'd4;
	localparam logic [2:0] REG_KEY_B_HIGH     = 3'd5;

	// Bus geometry
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	// Keystream state after reset or restart
	localparam logic [3:0] KEY_POS_A_INIT = 4'd0;
	localparam logic [3:0] KEY_POS_B_INIT = 4'd8;

	// Configuration seen by the keystream core
	typedef struct packed {
		logic         encrypt_enable;
		logic [30:0]  file_size;
		logic [127:0] key_a;
		logic [127:0] key_b;
	} cfg_t;

	// Pick one key byte from a 16-byte key
	function automatic logic [7:0] key_byte(input logic [127:0] key, input logic [3:0] idx);
		return key[{idx, 3'b000} +: 8];
	endfunction

	// Remainder by 7 of a 7-bit value: fold octal digits (8 is 1 mod 7)
	function automatic logic [2:0] mod7(input logic [6:0] n);
		logic [3:0] s;
		logic [3:0] t;
		s = {3'b000, n[6]} + {1'b0, n[5:3]} + {1'b0, n[2:0]};
		t = {3'b000, s[3]} + {1'b0, s[2:0]};
		if (t >= 4'd7) begin
			t = t - 4'd7;
		end
		return t[2:0];
	endfunction

	// Remainder by 12 of a 7-bit value: low two bits plus 4 * ((n >> 2) mod 3)
	function automatic logic [3:0] mod12(input logic [6:0] n);
		logic [2:0] s;
		s = {1'b0, n[3:2]} + {1'b0, n[5:4]} + {2'b00, n[6]};
		if (s >= 3'd6) begin
			s = s - 3'd6;
		end else if (s >= 3'd3) begin
			s = s - 3'd3;
		end
		return {s[1:0], n[1:0]};
	endfunction

endpackage
`default_nettype wire

>>> design/pfkd_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module pfkd_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [2:0]                  reg_idx,
	input  wire logic [pfkd_pkg::DATA_W-1:0] wr_data,
	output pfkd_pkg::cfg_t                   cfg,
	output logic [pfkd_pkg::DATA_W-1:0]      rd_data
);

	logic        encrypt_enable_q;
	logic [30:0] file_size_q;
	logic [63:0] key_a_low_q;
	logic [63:0] key_a_high_q;
	logic [63:0] key_b_low_q;
	logic [63:0] key_b_high_q;

	// Write the addressed register; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encrypt_enable_q <= 1'b0;
			file_size_q      <= '0;
			key_a_low_q      <= '0;
			key_a_high_q     <= '0;
			key_b_low_q      <= '0;
			key_b_high_q     <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				pfkd_pkg::REG_ENCRYPT_ENABLE: encrypt_enable_q <= wr_data[0];
				pfkd_pkg::REG_FILE_SIZE:      file_size_q      <= wr_data[30:0];
				pfkd_pkg::REG_KEY_A_LOW:      key_a_low_q      <= wr_data;
				pfkd_pkg::REG_KEY_A_HIGH:     key_a_high_q     <= wr_data;
				pfkd_pkg::REG_KEY_B_LOW:      key_b_low_q      <= wr_data;
				pfkd_pkg::REG_KEY_B_HIGH:     key_b_high_q     <= wr_data;
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (reg_idx)
			pfkd_pkg::REG_ENCRYPT_ENABLE: rd_data = {63'd0, encrypt_enable_q};
			pfkd_pkg::REG_FILE_SIZE:      rd_data = {33'd0, file_size_q};
			pfkd_pkg::REG_KEY_A_LOW:      rd_data = key_a_low_q;
			pfkd_pkg::REG_KEY_A_HIGH:     rd_data = key_a_high_q;
			pfkd_pkg::REG_KEY_B_LOW:      rd_data = key_b_low_q;
			pfkd_pkg::REG_KEY_B_HIGH:     rd_data = key_b_high_q;
			default:                      rd_data = '0;
		endcase
	end

	assign cfg.encrypt_enable = encrypt_enable_q;
	assign cfg.file_size      = file_size_q;
	assign cfg.key_a          = {key_a_high_q, key_a_low_q};
	assign cfg.key_b          = {key_b_high_q, key_b_low_q};

endmodule
`default_nettype wire

>>> design/pfkd_core.sv
// Keystream state and the per-byte decrypt and advance logic.
`timescale 1ns / 1ps
`default_nettype none
module pfkd_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  pfkd_pkg::cfg_t  cfg,
	input  wire logic       go,
	input  wire logic [1:0] action,
	input  wire logic [7:0] data_in,
	output logic [7:0]      byte_out
);

	logic [3:0] key_pos_a_q;
	logic [3:0] key_pos_b_q;
	logic [6:0] string_number_q;
	logic       nibble_swap_q;

	logic [3:0] key_pos_a_nxt;
	logic [3:0] key_pos_b_nxt;
	logic [6:0] string_number_nxt;
	logic       nibble_swap_nxt;

	logic [4:0] adv_a;
	logic [4:0] adv_b;
	logic [6:0] sn_step;
	logic [7:0] mix;

	// Decrypt the byte from the current keystream position, or pass it through when encryption is off
	always_comb begin
		mix = pfkd_pkg::key_byte(cfg.key_b, key_pos_b_q) ^ {1'b0, string_number_q} ^ data_in;
		if (nibble_swap_q) begin
			mix = {mix[3:0], mix[7:4]};
		end
		if (cfg.encrypt_enable) begin
			byte_out = mix ^ pfkd_pkg::key_byte(cfg.key_a, key_pos_a_q);
		end else begin
			byte_out = data_in;
		end
	end

	// Next keystream position
	always_comb begin
		adv_a             = {1'b0, key_pos_a_q} + 5'd1;
		adv_b             = {1'b0, key_pos_b_q} + 5'd1;
		sn_step           = string_number_q + 7'd2;
		key_pos_a_nxt     = key_pos_a_q;
		key_pos_b_nxt     = key_pos_b_q;
		string_number_nxt = string_number_q;
		nibble_swap_nxt   = nibble_swap_q;
		if (cfg.encrypt_enable) begin
			case (action)
				pfkd_pkg::ACT_DECRYPT, pfkd_pkg::ACT_SKIP: begin
					key_pos_a_nxt = adv_a[3:0];
					key_pos_b_nxt = adv_b[3:0];
					if (adv_a <= 5'd15) begin
						// index A still in range: wrap B past 12
						if (adv_b > 5'd12) begin
							key_pos_b_nxt   = 4'd0;
							nibble_swap_nxt = ~nibble_swap_q;
						end
					end else if (adv_b <= 5'd8) begin
						key_pos_a_nxt   = 4'd0;
						nibble_swap_nxt = ~nibble_swap_q;
					end else begin
						// both wrapped: step the string number and reload
						string_number_nxt = sn_step;
						if (nibble_swap_q) begin
							key_pos_a_nxt   = {1'b0, pfkd_pkg::mod7(sn_step)};
							key_pos_b_nxt   = pfkd_pkg::mod12(sn_step) + 4'd2;
							nibble_swap_nxt = 1'b0;
						end else begin
							key_pos_b_nxt   = {1'b0, pfkd_pkg::mod7(sn_step)};
							key_pos_a_nxt   = pfkd_pkg::mod12(sn_step) + 4'd3;
							nibble_swap_nxt = 1'b1;
						end
					end
				end
				pfkd_pkg::ACT_RESTART: begin
					string_number_nxt = cfg.file_size[8:2];
					key_pos_a_nxt     = pfkd_pkg::KEY_POS_A_INIT;
					key_pos_b_nxt     = pfkd_pkg::KEY_POS_B_INIT;
					nibble_swap_nxt   = 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Update the keystream state when a transaction leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pos_a_q     <= pfkd_pkg::KEY_POS_A_INIT;
			key_pos_b_q     <= pfkd_pkg::KEY_POS_B_INIT;
			string_number_q <= '0;
			nibble_swap_q   <= 1'b0;
		end else if (go) begin
			key_pos_a_q     <= key_pos_a_nxt;
			key_pos_b_q     <= key_pos_b_nxt;
			string_number_q <= string_number_nxt;
			nibble_swap_q   <= nibble_swap_nxt;
		end
	end

endmodule
`default_nettype wire

>>> design/pack_file_keystream_decryptor.sv
// Top level: input stage, keystream core, output register and configuration port.
// A decrypt transaction is held in the input stage, then in the output register.
// Throughput: one transaction per cycle; skip and restart retire without a result.
// The input stage stalls only while a finished byte waits in the output register.
// Reset (arst_n low, asynchronous): both stages empty, registers zero,
// key indices 0 and 8, string number 0, nibble swap clear.
`timescale 1ns / 1ps
`default_nettype none
module pack_file_keystream_decryptor (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [1:0]                  action,
	input  wire logic [7:0]                  data_in,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [7:0]                       data_out,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pfkd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [pfkd_pkg::DATA_W-1:0] pwdata,
	output logic [pfkd_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);

	pfkd_pkg::cfg_t cfg;

	logic       item_valid_s1;
	logic [1:0] action_s1;
	logic [7:0] data_s1;
	logic       out_valid_q;
	logic [7:0] data_out_q;
	logic       has_result;
	logic       go;
	logic [7:0] byte_out;

	// Configuration registers
	assign pready = 1'b1;

	pfkd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (psel && penable && pwrite),
		.reg_idx (paddr[5:3]),
		.wr_data (pwdata),
		.cfg     (cfg),
		.rd_data (prdata)
	);

	// Advance the input stage unless its byte has nowhere to go
	assign has_result = (action_s1 == pfkd_pkg::ACT_DECRYPT);
	assign go         = item_valid_s1 && (!has_result || !out_valid_q || !out_stall);
	assign in_stall   = item_valid_s1 && !go;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			item_valid_s1 <= 1'b1;
		end else if (go) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			data_s1   <= data_in;
		end
	end

	pfkd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.go       (go),
		.action   (action_s1),
		.data_in  (data_s1),
		.byte_out (byte_out)
	);

	// Output register: load a decrypted byte, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && has_result) begin
			data_out_q <= byte_out;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;

endmodule
`default_nettype wire

>>> design/pfkd_checker.sv
// Port-level checks for the decryptor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pfkd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [1:0] action,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] data_out
);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_out))
		else $error("result changed while stalled");

	// The input side stalls only behind a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with a free output");

	// A new result comes from an accepted decrypt transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |->
			$past(in_valid && !in_stall && action == pfkd_pkg::ACT_DECRYPT, 2))
		else $error("result without a decrypt transaction");

	// Nothing is pending right after reset
	assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present after reset");

endmodule

bind pack_file_keystream_decryptor pfkd_checker u_pfkd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.action    (action),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.data_out  (data_out)
);
`default_nettype wire

>>> sim/tb_pack_file_keystream_decryptor.sv
// Self-checking testbench for the archive keystream byte decryptor.
`timescale 1ns / 1ps
module tb_pack_file_keystream_decryptor;

	// Action code the block ignores
	localparam logic [1:0] ACT_UNDEFINED = 2'd3;

	// Keystream index bounds
	localparam int KEY_A_LAST   = 15;
	localparam int KEY_B_WRAP   = 12;
	localparam int KEY_B_REFILL = 8;

	localparam int DRAIN_CYCLES   = 4;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int MAX_REPORTS    = 10;
	localparam int RANDOM_PHASES  = 8;
	localparam int ITEMS_PER_PHASE = 75;

	typedef enum int {STALL_NONE, STALL_SCATTER, STALL_RUNS} stall_mode_t;

	// Keystream predictor and store of expected output bytes
	class keystream_scoreboard;
		bit          enc_en;
		bit [30:0]   fsize;
		bit [127:0]  key_a;
		bit [127:0]  key_b;
		bit [3:0]    pos_a;
		bit [3:0]    pos_b;
		bit [6:0]    str_num;
		bit          swap;
		logic [7:0]  expected_bytes[$];
		int          errors;
		int          n_decrypt;
		int          n_skip;
		int          n_restart;
		int          n_ignored;
		int          n_checked;

		function new();
			enc_en = 1'b0;
			fsize = '0;
			key_a = '0;
			key_b = '0;
			pos_a = pfkd_pkg::KEY_POS_A_INIT;
			pos_b = pfkd_pkg::KEY_POS_B_INIT;
			str_num = '0;
			swap = 1'b0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [63:0] val);
			case (idx)
				pfkd_pkg::REG_ENCRYPT_ENABLE: enc_en = val[0];
				pfkd_pkg::REG_FILE_SIZE:      fsize = val[30:0];
				pfkd_pkg::REG_KEY_A_LOW:      key_a[63:0] = val;
				pfkd_pkg::REG_KEY_A_HIGH:     key_a[127:64] = val;
				pfkd_pkg::REG_KEY_B_LOW:      key_b[63:0] = val;
				pfkd_pkg::REG_KEY_B_HIGH:     key_b[127:64] = val;
				default: ;
			endcase
		endfunction

		// Step both indices; on double overrun bump the string number and reload
		function void advance_indices();
			int a;
			int b;
			int n;
			a = pos_a + 1;
			b = pos_b + 1;
			if (a <= KEY_A_LAST) begin
				if (b > KEY_B_WRAP) begin
					b = 0;
					swap = ~swap;
				end
			end else if (b <= KEY_B_REFILL) begin
				a = 0;
				swap = ~swap;
			end else begin
				str_num = str_num + 7'd2;
				n = str_num;
				if (swap) begin
					a = n % 7;
					b = n % 12 + 2;
					swap = 1'b0;
				end else begin
					b = n % 7;
					a = n % 12 + 3;
					swap = 1'b1;
				end
			end
			pos_a = a[3:0];
			pos_b = b[3:0];
		endfunction

		function void note_input(logic [1:0] act, logic [7:0] din);
			logic [7:0] v;
			v = din;
			case (act)
				pfkd_pkg::ACT_DECRYPT: begin
					n_decrypt++;
					if (enc_en) begin
						v = key_b[{pos_b, 3'b000} +: 8] ^ {1'b0, str_num} ^ v;
						if (swap) begin
							v = {v[3:0], v[7:4]};
						end
						v = v ^ key_a[{pos_a, 3'b000} +: 8];
						advance_indices();
					end
					expected_bytes.push_back(v);
				end
				pfkd_pkg::ACT_SKIP: begin
					n_skip++;
					if (enc_en) begin
						advance_indices();
					end
				end
				pfkd_pkg::ACT_RESTART: begin
					n_restart++;
					if (enc_en) begin
						str_num = fsize[8:2];
						pos_a = pfkd_pkg::KEY_POS_A_INIT;
						pos_b = pfkd_pkg::KEY_POS_B_INIT;
						swap = 1'b0;
					end
				end
				default: n_ignored++;
			endcase
		endfunction

		function void check_output(logic [7:0] got);
			logic [7:0] want;
			if (expected_bytes.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("[%0t] unexpected output transaction: data_out %02h", $time, got);
				end
				return;
			end
			want = expected_bytes.pop_front();
			n_checked++;
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("[%0t] data_out mismatch: expected %02h, got %02h",
						$time, want, got);
				end
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [1:0]                    action = pfkd_pkg::ACT_DECRYPT;
	logic [7:0]                    data_in = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [7:0]                    data_out;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [pfkd_pkg::ADDR_W-1:0]   paddr = '0;
	logic [pfkd_pkg::DATA_W-1:0]   pwdata = '0;
	logic [pfkd_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	keystream_scoreboard  sb = new();
	int                   cycle_count = 0;
	int                   n_settings = 0;
	stall_mode_t          stall_mode = STALL_NONE;
	int                   mode_left = 0;
	int                   stall_hold = 0;

	pack_file_keystream_decryptor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.data_in   (data_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_out  (data_out),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Check output transactions and stall the output on a shifting pattern
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			sb.check_output(data_out);
		end
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 2));
			mode_left = $urandom_range(20, 120);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_SCATTER: out_stall <= ($urandom_range(0, 2) == 0);
			default: begin
				if (stall_hold > 0) begin
					stall_hold--;
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
					if ($urandom_range(0, 3) == 0) begin
						stall_hold = $urandom_range(1, 6);
					end
				end
			end
		endcase
	end

	// Present one transaction and hold it until accepted
	task automatic drive_item(input logic [1:0] act, input logic [7:0] din);
		in_valid <= 1'b1;
		action <= act;
		data_in <= din;
		@(posedge clk);
		while (in_stall !== 1'b0) begin
			@(posedge clk);
		end
		sb.note_input(act, din);
	endtask

	// Drop valid for a number of cycles with junk on the payload
	task automatic idle_cycles(input int n);
		in_valid <= 1'b0;
		action <= 2'($urandom_range(0, 3));
		data_in <= 8'($urandom_range(0, 255));
		repeat (n) @(posedge clk);
	endtask

	// Hold off until every expected byte has come out, then let the pipe settle
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) begin
			@(posedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	function automatic logic [63:0] pick_key_word();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] pick_file_size();
		case ($urandom_range(0, 3))
			0: return 64'd0;
			1: return 64'h7FFF_FFFF;
			2: return 64'($urandom_range(0, 511));
			default: return 64'($urandom & 32'h7FFF_FFFF);
		endcase
	endfunction

	function automatic logic [1:0] pick_action();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			return ACT_UNDEFINED;
		end else if (r < 7) begin
			return pfkd_pkg::ACT_RESTART;
		end else if (r < 55) begin
			return pfkd_pkg::ACT_DECRYPT;
		end
		return pfkd_pkg::ACT_SKIP;
	endfunction

	// Write the enable and, at random or all when write_all is set, the other registers
	task automatic apply_setting(input bit enable, input bit write_all);
		write_reg(pfkd_pkg::REG_ENCRYPT_ENABLE, {63'd0, enable});
		if (write_all || $urandom_range(0, 1))
			write_reg(pfkd_pkg::REG_FILE_SIZE, pick_file_size());
		if (write_all || $urandom_range(0, 1))
			write_reg(pfkd_pkg::REG_KEY_A_LOW, pick_key_word());
		if (write_all || $urandom_range(0, 1))
			write_reg(pfkd_pkg::REG_KEY_A_HIGH, pick_key_word());
		if (write_all || $urandom_range(0, 1))
			write_reg(pfkd_pkg::REG_KEY_B_LOW, pick_key_word());
		if (write_all || $urandom_range(0, 1))
			write_reg(pfkd_pkg::REG_KEY_B_HIGH, pick_key_word());
		n_settings++;
	endtask

	// Random traffic in bursts; ignored actions do not count toward n
	task automatic run_random(input int n, input bit pause_midway);
		int sent;
		int burst;
		logic [1:0] act;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 20);
			while (burst > 0 && sent < n) begin
				act = pick_action();
				drive_item(act, 8'($urandom_range(0, 255)));
				if (act != ACT_UNDEFINED) begin
					sent++;
				end
				burst--;
				if (pause_midway && sent == n / 2) begin
					wait_drain();
					pause_midway = 1'b0;
				end
			end
			if ($urandom_range(0, 3) != 0) begin
				idle_cycles($urandom_range(1, 6));
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pass-through with reset values
		n_settings++;
		drive_item(pfkd_pkg::ACT_DECRYPT, 8'h00);
		drive_item(pfkd_pkg::ACT_DECRYPT, 8'hFF);
		drive_item(pfkd_pkg::ACT_SKIP, 8'h3C);
		drive_item(pfkd_pkg::ACT_RESTART, 8'h00);
		drive_item(ACT_UNDEFINED, 8'hA5);
		drive_item(pfkd_pkg::ACT_DECRYPT, 8'h5A);
		wait_drain();

		// Full setup with the widest file size, then walk the indices through a wrap of index B
		write_reg(pfkd_pkg::REG_ENCRYPT_ENABLE, 64'd1);
		write_reg(pfkd_pkg::REG_FILE_SIZE, 64'h7FFF_FFFF);
		write_reg(pfkd_pkg::REG_KEY_A_LOW, {$urandom, $urandom});
		write_reg(pfkd_pkg::REG_KEY_A_HIGH, {$urandom, $urandom});
		write_reg(pfkd_pkg::REG_KEY_B_LOW, {$urandom, $urandom});
		write_reg(pfkd_pkg::REG_KEY_B_HIGH, {$urandom, $urandom});
		n_settings++;
		drive_item(pfkd_pkg::ACT_DECRYPT, 8'h00);
		drive_item(pfkd_pkg::ACT_DECRYPT, 8'hFF);
		drive_item(pfkd_pkg::ACT_SKIP, 8'h00);
		drive_item(ACT_UNDEFINED, 8'h00);
		drive_item(pfkd_pkg::ACT_RESTART, 8'hFF);
		for (int i = 0; i < 12; i++) begin
			drive_item((i % 3 == 0) ? pfkd_pkg::ACT_DECRYPT : pfkd_pkg::ACT_SKIP,
				8'($urandom_range(0, 255)));
		end
		wait_drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			apply_setting(p != 2, p == 0);
			run_random(ITEMS_PER_PHASE, p == 4);
			wait_drain();
		end

		if (sb.pending() != 0) begin
			sb.errors++;
			$display("%0d expected bytes never came out", sb.pending());
		end
		$display("Covered %0d decrypts, %0d skips, %0d restarts, %0d ignored actions",
			sb.n_decrypt, sb.n_skip, sb.n_restart, sb.n_ignored);
		$display("over %0d register settings; %0d bytes checked, %0d errors",
			n_settings, sb.n_checked, sb.errors);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
